[hw/rtl/mnps_pkg.sv]
// Shared types and constants for the mono note priority stack.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mnps_pkg;

   localparam int unsigned NOTE_W   = 7;
   localparam int unsigned DATA_W   = 7;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned GATE_W   = 4;
   localparam int unsigned ACTIVE_W = 2;

   localparam int unsigned REQ_DATA_W = 16;  // note, data, zero pad
   localparam int unsigned RSP_DATA_W = 32;  // gate, pitch, velocity, voice, detune, pad

   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_MOD_WHL  = 2'd2;

   localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CIRCULAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNISON   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load_item;  // capture the incoming transaction
      logic match;      // register the stack compare
      logic apply;      // update state and load the result register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;   // result register can take a new result this cycle
   } dp_status_type;

endpackage

[hw/rtl/mnps_ctrl.sv]
// Sequencer for the note stack: capture, compare, apply.
// Depends on mnps_pkg.
`timescale 1ns / 1ps

module mnps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mnps_pkg::dp_status_type status,
   output mnps_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      req_tready    = 1'b0;
      cmd.load_item = 1'b0;
      cmd.match     = 1'b0;
      cmd.apply     = 1'b0;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            // take the next item in the same cycle the result is loaded
            if (status.out_free) begin
               cmd.apply  = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load_item = 1'b1;
                  state_in      = ST_MATCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/mnps_datapath.sv]
// Note stack, voice state and result register.
// Depends on mnps_pkg; sequenced by mnps_ctrl.
`timescale 1ns / 1ps

module mnps_datapath #(
   parameter int unsigned STACK_DEPTH = 8,
   parameter int unsigned VOICE_COUNT = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mnps_pkg::ctl_cmd_type                 cmd,
   output mnps_pkg::dp_status_type               status,
   input  logic [mnps_pkg::OP_W-1:0]             req_opcode,
   input  logic [mnps_pkg::NOTE_W-1:0]           req_note,
   input  logic [mnps_pkg::DATA_W-1:0]           req_data,
   input  logic                                 csr_write,
   input  logic [mnps_pkg::MODE_W-1:0]           csr_mode,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mnps_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int unsigned PTR_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(VOICE_COUNT - 1);

   // captured transaction
   logic [mnps_pkg::OP_W-1:0]   op_ff;
   logic [mnps_pkg::NOTE_W-1:0] note_ff;
   logic [mnps_pkg::DATA_W-1:0] data_ff;

   // architectural state
   logic [mnps_pkg::NOTE_W-1:0] stack_ff [STACK_DEPTH];
   logic [mnps_pkg::NOTE_W-1:0] stack_in [STACK_DEPTH];
   logic [mnps_pkg::NOTE_W-1:0] latched_ff, latched_in;
   logic [mnps_pkg::DATA_W-1:0] velocity_ff, velocity_in;
   logic [PTR_W-1:0]            ptr_ff, ptr_in;
   logic [mnps_pkg::DATA_W-1:0] detune_ff, detune_in;
   logic [mnps_pkg::MODE_W-1:0] mode_ff;

   // compare stage: tail_ff[i] set when a match sits at or above slot i
   logic [STACK_DEPTH-1:0] eq_vec;
   logic [STACK_DEPTH-1:0] tail_ff;
   logic                   found;

   // result register
   logic                          out_valid_ff;
   logic [mnps_pkg::GATE_W-1:0]   gate_ff, gate_in;
   logic [mnps_pkg::NOTE_W-1:0]   pitch_ff;
   logic [mnps_pkg::DATA_W-1:0]   vel_out_ff;
   logic [mnps_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [mnps_pkg::DATA_W-1:0]   detune_out_ff;

   logic push_note, remove_note, is_off;
   logic [mnps_pkg::NOTE_W-1:0] new_top;

   assign status.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_opcode;
         note_ff <= req_note;
         data_ff <= req_data;
      end
   end

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         eq_vec[i] = (stack_ff[i] == note_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         for (int i = 0; i < STACK_DEPTH; i++) begin
            tail_ff[i] <= |(eq_vec & STACK_DEPTH'((64'd2 << i) - 64'd1));
         end
      end
   end

   assign found = tail_ff[STACK_DEPTH-1];

   // note on for a new note that is not already on top
   assign push_note   = (op_ff == mnps_pkg::OP_NOTE_ON) && (note_ff != '0) &&
                        (note_ff != stack_ff[0]);
   assign is_off      = (op_ff == mnps_pkg::OP_NOTE_OFF);
   assign remove_note = is_off && found;

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (push_note && !found) begin
         stack_in[0] = note_ff;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (remove_note) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_in[i] = tail_ff[i] ? stack_ff[i+1] : stack_ff[i];
         end
         stack_in[STACK_DEPTH-1] = tail_ff[STACK_DEPTH-1] ? '0 : stack_ff[STACK_DEPTH-1];
      end
   end

   assign new_top = stack_in[0];

   always_comb begin
      latched_in  = latched_ff;
      velocity_in = velocity_ff;
      ptr_in      = ptr_ff;
      detune_in   = detune_ff;
      if (push_note) begin
         latched_in  = new_top;
         velocity_in = data_ff;
         if (mode_ff == mnps_pkg::MODE_CIRCULAR) begin
            ptr_in = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
         end
      end else if (is_off) begin
         latched_in = (new_top != '0) ? new_top : stack_ff[0];
         if (new_top == '0) begin
            velocity_in = '0;
         end
      end else if (op_ff == mnps_pkg::OP_MOD_WHL && mode_ff == mnps_pkg::MODE_UNISON) begin
         detune_in = data_ff;
      end
   end

   // gate and voice index from the post-update state
   always_comb begin
      gate_in   = '0;
      active_in = '0;
      unique case (mode_ff)
         mnps_pkg::MODE_CIRCULAR: begin
            active_in = mnps_pkg::ACTIVE_W'(ptr_in);
            for (int v = 0; v < mnps_pkg::GATE_W; v++) begin
               gate_in[v] = (new_top != '0) && (32'(ptr_in) == v);
            end
         end
         mnps_pkg::MODE_UNISON: begin
            for (int v = 0; v < mnps_pkg::GATE_W; v++) begin
               gate_in[v] = (new_top != '0) && (v < VOICE_COUNT);
            end
         end
         default: begin
            gate_in[0] = (new_top != '0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) begin
            stack_ff[i] <= '0;
         end
         latched_ff   <= '0;
         velocity_ff  <= '0;
         ptr_ff       <= '0;
         detune_ff    <= '0;
         mode_ff      <= mnps_pkg::MODE_SINGLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_mode;
         end
         if (cmd.apply) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
               stack_ff[i] <= stack_in[i];
            end
            latched_ff   <= latched_in;
            velocity_ff  <= velocity_in;
            ptr_ff       <= ptr_in;
            detune_ff    <= detune_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         gate_ff       <= gate_in;
         pitch_ff      <= latched_in;
         vel_out_ff    <= velocity_in;
         active_ff     <= active_in;
         detune_out_ff <= detune_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, detune_out_ff, active_ff, vel_out_ff, pitch_ff, gate_ff};

endmodule

[hw/rtl/mono_note_priority_stack.sv]
// Top level of the last-note-priority note stack.
// Depends on mnps_pkg, mnps_ctrl and mnps_datapath.
`timescale 1ns / 1ps
//
// Usage
//  req_*  : one MIDI event per transaction. tuser carries the opcode
//           (note on, note off, mod wheel); tdata carries note and value.
//  rsp_*  : exactly one result per event, in order: gate mask, latched
//           pitch note, velocity, voice index and detune after the event.
//  csr_*  : voice mode register (single, circulating, unison). Write it
//           only while no event is in flight.
// Timing
//  An event passes through a stack compare state and an update state that
//  registers its result. The update state also accepts the next event, so
//  a new event is taken only as the last is applied and the result register
//  is free; the compare-then-shift over the held-note stack sets this limit.
// Reset
//  Synchronous, active high: stack empty, pitch, velocity, voice index,
//  detune and mode all zero, no result pending.
// Stall
//  A result waits in the output register while rsp_tready is low; the block
//  then holds the finished event in its update cycle and takes no new one.
//
module mono_note_priority_stack #(
   parameter int unsigned STACK_DEPTH = 8,
   parameter int unsigned VOICE_COUNT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [6:0] note_number, [13:7] data_value, [15:14] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mnps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: [1:0] opcode
   input  logic [mnps_pkg::OP_W-1:0]           req_tuser,
   // rsp_tdata: [3:0] gate_mask, [10:4] pitch_note, [17:11] level_velocity,
   //            [19:18] active_voice, [26:20] detune_amount, [31:27] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mnps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // voice_mode write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mnps_pkg::MODE_W-1:0]         csr_data
);

   mnps_pkg::ctl_cmd_type   cmd;
   mnps_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   mnps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mnps_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VOICE_COUNT (VOICE_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_opcode (req_tuser),
      .req_note   (req_tdata[6:0]),
      .req_data   (req_tdata[13:7]),
      .csr_write  (csr_valid && csr_ready),
      .csr_mode   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // an accepted event always blocks the following cycle (compare stage)
   a_accept_spacing: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("event accepted during compare cycle");

   // the update never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten");

   // every update shows up as a result on the next cycle
   a_apply_result: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_tvalid)
      else $error("update without result");

endmodule

[sim/testbench.sv]
// Self-checking testbench for mono_note_priority_stack (note stack, latch, voice, detune).
// Needs mnps_pkg and the RTL of the block; stimulus is a directed table plus random
// events in every voice mode, checked against typed rows or an in-bench model of the note stack.
`timescale 1ns / 1ps

module testbench;

   localparam int STACK_DEPTH = 8;
   localparam int VOICE_COUNT = 4;
   localparam int STALL_LIMIT = 2000;  // cycles with no transaction on any channel
   localparam int PHASE_ITEMS = 155;
   localparam int REPORT_MAX  = 10;

   // ignored opcode, still answered
   localparam logic [mnps_pkg::OP_W-1:0]   OP_UNUSED  = 2'd3;
   // behaves as single voice
   localparam logic [mnps_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   // one result transaction, field order matches rsp_tdata from the MSB down
   typedef struct packed {
      logic [6:0] detune;
      logic [1:0] voice;
      logic [6:0] velocity;
      logic [6:0] pitch;
      logic [3:0] gate;
   } voice_state_type;

   // directed event; the expected gate/pitch/velocity is used only when typed is set
   typedef struct packed {
      logic [mnps_pkg::OP_W-1:0] op;
      logic [6:0]                note;
      logic [6:0]                value;
      logic                      typed;
      logic [3:0]                gate;
      logic [6:0]                pitch;
      logic [6:0]                velocity;
   } event_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam event_row_type DIRECTED [DIRECTED_ROWS] = '{
      // nothing held yet: wheel, note off, note on zero and the unused opcode all idle
      '{mnps_pkg::OP_MOD_WHL,   7'd0,   7'd127, 1'b1, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_OFF,  7'd0,   7'd0,   1'b1, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd0,   7'd100, 1'b1, 4'd0, 7'd0,   7'd0},
      '{OP_UNUSED,              7'd127, 7'd127, 1'b1, 4'd0, 7'd0,   7'd0},
      // top note extremes; repeating the top leaves velocity alone
      '{mnps_pkg::OP_NOTE_ON,   7'd127, 7'd127, 1'b1, 4'd1, 7'd127, 7'd127},
      '{mnps_pkg::OP_NOTE_ON,   7'd127, 7'd5,   1'b1, 4'd1, 7'd127, 7'd127},
      '{mnps_pkg::OP_NOTE_ON,   7'd1,   7'd1,   1'b1, 4'd1, 7'd1,   7'd1},
      // held but not on top: no reorder, velocity still taken
      '{mnps_pkg::OP_NOTE_ON,   7'd127, 7'd64,  1'b1, 4'd1, 7'd1,   7'd64},
      '{mnps_pkg::OP_NOTE_OFF,  7'd1,   7'd0,   1'b1, 4'd1, 7'd127, 7'd64},
      // last release keeps the old pitch, clears velocity
      '{mnps_pkg::OP_NOTE_OFF,  7'd127, 7'd0,   1'b1, 4'd0, 7'd127, 7'd0},
      // unknown note off on an empty stack latches the empty top
      '{mnps_pkg::OP_NOTE_OFF,  7'd99,  7'd0,   1'b1, 4'd0, 7'd0,   7'd0},
      // nine distinct notes overflow the stack, the oldest is lost
      '{mnps_pkg::OP_NOTE_ON,   7'd10,  7'd11,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd20,  7'd22,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd30,  7'd33,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd40,  7'd44,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd50,  7'd55,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd60,  7'd66,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd70,  7'd77,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd80,  7'd88,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_ON,   7'd90,  7'd99,  1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_OFF,  7'd10,  7'd0,   1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_OFF,  7'd90,  7'd0,   1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_OFF,  7'd50,  7'd0,   1'b0, 4'd0, 7'd0,   7'd0},
      '{mnps_pkg::OP_NOTE_OFF,  7'd0,   7'd0,   1'b0, 4'd0, 7'd0,   7'd0}
   };

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mnps_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [mnps_pkg::OP_W-1:0]       req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mnps_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [mnps_pkg::MODE_W-1:0]     csr_data   = '0;

   // model state of the note stack
   logic [6:0]                  held_notes [STACK_DEPTH];
   logic [6:0]                  top_of_stack;
   logic [6:0]                  pitch_latch;
   logic [6:0]                  velocity_now;
   logic [1:0]                  voice_ptr;
   logic [6:0]                  detune_now;
   logic [mnps_pkg::MODE_W-1:0] voice_mode_now;

   voice_state_type pending_results [$];
   int              mismatch_count = 0;
   int              idle_pct  = 0;   // sender gap chance per transaction
   int              stall_pct = 0;   // receiver stall chance per cycle
   int              stall_left = 0;
   int              quiet_cycles = 0;

   always #5 clock = ~clock;

   mono_note_priority_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .VOICE_COUNT (VOICE_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Apply one event to the model and return the state the block should report.
   function automatic voice_state_type predict_note_event(
         input logic [mnps_pkg::OP_W-1:0] op,
         input logic [6:0] note,
         input logic [6:0] value);
      voice_state_type res;
      logic [6:0]      old_top;
      int              hit;
      bit              found;
      res     = '0;
      old_top = held_notes[0];
      hit     = -1;
      found   = 1'b0;
      unique case (op)
         mnps_pkg::OP_NOTE_ON: begin
            if (note != 7'd0 && note != top_of_stack) begin
               for (int i = 0; i < STACK_DEPTH; i++)
                  if (held_notes[i] == note) found = 1'b1;
               if (!found) begin
                  for (int i = STACK_DEPTH - 1; i > 0; i--) held_notes[i] = held_notes[i-1];
                  held_notes[0] = note;
               end
               top_of_stack = held_notes[0];
               pitch_latch  = top_of_stack;
               velocity_now = value;
               if (voice_mode_now == mnps_pkg::MODE_CIRCULAR)
                  voice_ptr = (voice_ptr == VOICE_COUNT - 1) ? 2'd0 : voice_ptr + 2'd1;
            end
         end
         mnps_pkg::OP_NOTE_OFF: begin
            for (int i = 0; i < STACK_DEPTH; i++)
               if (hit < 0 && held_notes[i] == note) hit = i;
            if (hit >= 0) begin
               for (int i = hit; i < STACK_DEPTH - 1; i++) held_notes[i] = held_notes[i+1];
               held_notes[STACK_DEPTH-1] = 7'd0;
            end
            // an empty stack keeps the pitch of the note that was on top
            pitch_latch  = (held_notes[0] != 7'd0) ? held_notes[0] : old_top;
            top_of_stack = held_notes[0];
            if (top_of_stack == 7'd0) velocity_now = 7'd0;
         end
         mnps_pkg::OP_MOD_WHL: begin
            if (voice_mode_now == mnps_pkg::MODE_UNISON) detune_now = value;
         end
         default: ;
      endcase

      if (top_of_stack != 7'd0) begin
         if (voice_mode_now == mnps_pkg::MODE_CIRCULAR)
            res.gate = 4'd1 << voice_ptr;
         else if (voice_mode_now == mnps_pkg::MODE_UNISON)
            res.gate = 4'((1 << VOICE_COUNT) - 1);
         else
            res.gate = 4'd1;
      end
      res.voice    = (voice_mode_now == mnps_pkg::MODE_CIRCULAR) ? voice_ptr : 2'd0;
      res.pitch    = pitch_latch;
      res.velocity = velocity_now;
      res.detune   = detune_now;
      return res;
   endfunction

   // Send one event; queue either the typed expectation or the predicted one.
   task automatic send_event(input logic [mnps_pkg::OP_W-1:0] op, input logic [6:0] note,
                             input logic [6:0] value, input bit use_typed,
                             input voice_state_type typed_result);
      voice_state_type predicted;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, value, note};
      do @(posedge clock); while (!req_tready);
      predicted = predict_note_event(op, note, value);
      pending_results.push_back(use_typed ? typed_result : predicted);
   endtask

   // Wait until every expected transaction is back, then let the pipeline settle.
   task automatic drain_results();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_voice_mode(input logic [mnps_pkg::MODE_W-1:0] mode);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      voice_mode_now = mode;
   endtask

   // Random events: mostly a small pool of notes so that releases hit held notes
   // and the stack overflows now and then; the rest spans every field value.
   task automatic play_random_events(input int count);
      logic [mnps_pkg::OP_W-1:0] op;
      logic [6:0]                note;
      logic [6:0]                value;
      int                        pick;
      int                        depth;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0 && idle_pct != 0) idle_pct = $urandom_range(0, 1) ? 0 : 35;
         pick  = $urandom_range(0, 99);
         value = $urandom_range(0, 127);
         note  = ($urandom_range(0, 4) != 0) ? 7'(60 + $urandom_range(0, 11))
                                             : 7'($urandom_range(0, 127));
         if (pick < 45) begin
            op = mnps_pkg::OP_NOTE_ON;
         end else if (pick < 80) begin
            op    = mnps_pkg::OP_NOTE_OFF;
            depth = 0;
            for (int i = 0; i < STACK_DEPTH; i++) if (held_notes[i] != 7'd0) depth++;
            if (depth != 0 && $urandom_range(0, 9) < 7)
               note = held_notes[$urandom_range(0, depth - 1)];
         end else if (pick < 95) begin
            op = mnps_pkg::OP_MOD_WHL;
         end else begin
            op = OP_UNUSED;
         end
         send_event(op, note, value, 1'b0, '0);
      end
   endtask

   // Receiver: random stall bursts while stall_pct is nonzero.
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 12) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: compare each accepted transaction with the oldest expectation.
   always @(posedge clock) begin
      voice_state_type want;
      voice_state_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[26:0];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected result tdata=%h", $realtime, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got.gate !== want.gate || got.pitch !== want.pitch ||
                got.velocity !== want.velocity || got.voice !== want.voice ||
                got.detune !== want.detune || rsp_tdata[31:27] !== 5'd0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"%0t: mismatch gate %h/%h pitch %0d/%0d vel %0d/%0d",
                            " voice %0d/%0d detune %0d/%0d pad %h (exp/act)"},
                           $realtime, want.gate, got.gate, want.pitch, got.pitch,
                           want.velocity, got.velocity, want.voice, got.voice,
                           want.detune, got.detune, rsp_tdata[31:27]);
            end
         end
      end
   end

   // Watchdog: any accepted transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $realtime, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [mnps_pkg::MODE_W-1:0] phase_modes [6];
      voice_state_type             typed_result;
      phase_modes = '{mnps_pkg::MODE_CIRCULAR, mnps_pkg::MODE_UNISON, MODE_SPARE,
                      mnps_pkg::MODE_SINGLE, mnps_pkg::MODE_UNISON,
                      mnps_pkg::MODE_CIRCULAR};

      for (int i = 0; i < STACK_DEPTH; i++) held_notes[i] = 7'd0;
      top_of_stack   = 7'd0;
      pitch_latch    = 7'd0;
      velocity_now   = 7'd0;
      voice_ptr      = 2'd0;
      detune_now     = 7'd0;
      voice_mode_now = mnps_pkg::MODE_SINGLE;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table in the reset mode (single voice)
      idle_pct  = 20;
      stall_pct = 20;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         typed_result          = '0;
         typed_result.gate     = DIRECTED[r].gate;
         typed_result.pitch    = DIRECTED[r].pitch;
         typed_result.velocity = DIRECTED[r].velocity;
         send_event(DIRECTED[r].op, DIRECTED[r].note, DIRECTED[r].value,
                    DIRECTED[r].typed, typed_result);
      end

      // random phases; each waits for all results before the mode changes,
      // and the last one runs with no gaps and no stalls
      for (int p = 0; p < 6; p++) begin
         req_tvalid <= 1'b0;
         drain_results();
         if (p == 5) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 25;
            stall_pct = (p % 2 == 0) ? 15 : 40;
         end
         write_voice_mode(phase_modes[p]);
         play_random_events(PHASE_ITEMS);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
